>>> design/pksm_pkg.sv
package pksm_pkg;

    localparam int KEY_IDX_W = 7;
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 21;
    localparam int DECAY_W   = 16;
    localparam int SUM_W     = 24;
    localparam int TALLY_W   = 7;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
    localparam int SCALED_W  = PROD_W - 20;
    localparam int SCALE_SHIFT = 20;

    localparam logic REQ_SCAN  = 1'b0;
    localparam logic REQ_VOICE = 1'b1;

    localparam logic RES_STATUS = 1'b0;
    localparam logic RES_FRAME  = 1'b1;

    localparam logic REG_DECAY_STEP = 1'b0;
    localparam logic REG_GAIN_FLOOR = 1'b1;

    localparam logic [DECAY_W-1:0] DECAY_STEP_RESET = 16'd52;
    localparam logic [GAIN_W-1:0]  GAIN_FLOOR_RESET = 21'd10486;
    localparam logic [GAIN_W-1:0]  GAIN_ONE         = 21'd1048576;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << SCALE_SHIFT) - 1);
    localparam logic signed [SUM_W:0]    SUM_MAX    = (SUM_W+1)'(8388607);
    localparam logic signed [SUM_W:0]    SUM_MIN    = -(SUM_W+1)'(8388608);
    localparam logic [TALLY_W-1:0]       TALLY_MAX  = 7'd127;
    localparam logic signed [SUM_W-1:0]  OUT_HIGH   = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0]  OUT_LOW    = -SUM_W'(32767);

    typedef enum logic [2:0] {
        NOTE_IDLE    = 3'b001,
        NOTE_HELD    = 3'b010,
        NOTE_SUSTAIN = 3'b100
    } note_t;

    typedef enum logic [2:0] {
        HIST_NONE    = 3'b001,
        HIST_PRESSED = 3'b010,
        HIST_ARMED   = 3'b100
    } hist_t;

    typedef struct packed {
        note_t              state;
        hist_t              hist;
        logic [GAIN_W-1:0]  gain;
    } note_rec_t;

    localparam note_rec_t REC_RESET = '{state: NOTE_IDLE, hist: HIST_NONE, gain: '0};

    typedef struct packed {
        logic                       kind;
        logic                       key_ok;
        logic [KEY_IDX_W-1:0]       key;
        logic                       key_down;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } item_t;

    typedef struct packed {
        logic                       kind;
        logic                       active;
        logic                       restart;
        logic signed [SAMPLE_W-1:0] mixed;
        logic [TALLY_W-1:0]         count;
    } res_t;

endpackage

>>> design/pksm_ram.sv
module pksm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/pksm_fifo.sv
module pksm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [WIDTH-1:0]                wr_data,
    input  logic                            pop,
    output logic [WIDTH-1:0]                rd_data,
    output logic                            full,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PTR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             wr_en;
    logic             rd_en;

    assign wr_en = push && !full;
    assign rd_en = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule

>>> design/pksm_front.sv
module pksm_front
    import pksm_pkg::*;
#(
    parameter int NUM_KEYS    = 88,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        req_type,
    input  logic [KEY_IDX_W-1:0]        key_index,
    input  logic                        key_down,
    input  logic signed [SAMPLE_W-1:0]  voice_sample,
    input  logic                        last_voice,
    input  logic                        q_pop,
    output logic                        q_empty,
    output item_t                       q_item
);

    item_t in_item;

    // range check and packing of the incoming item
    always_comb
    begin
        in_item.kind     = req_type;
        in_item.key_ok   = ({1'b0, key_index} < (KEY_IDX_W+1)'(NUM_KEYS));
        in_item.key      = key_index;
        in_item.key_down = key_down;
        in_item.sample   = voice_sample;
        in_item.last     = last_voice;
    end

    pksm_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (in_item),
        .pop     (q_pop),
        .rd_data (q_item),
        .full    (full),
        .empty   (q_empty),
        .count   ()
    );

endmodule

>>> design/pksm_back.sv
module pksm_back
    import pksm_pkg::*;
#(
    parameter int NUM_KEYS  = 88,
    parameter int OUT_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [DECAY_W-1:0]                  decay_step,
    input  logic [GAIN_W-1:0]                   gain_floor,
    input  logic                                q_empty,
    input  item_t                               q_item,
    output logic                                q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]      out_count,
    output logic                                res_push,
    output res_t                                res_data
);

    localparam int KEY_W = $clog2(NUM_KEYS > 1 ? NUM_KEYS : 2);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int OCC_W = CNT_W + 3;

    // issue
    logic [OCC_W-1:0] occupancy;
    logic             issue;

    // stage b: record read, key update, multiply
    logic              b_valid_reg;
    item_t             b_item_reg;
    logic [KEY_W-1:0]  b_addr;
    logic [KEY_W-1:0]  rd_addr;
    logic [$bits(note_rec_t)-1:0] ram_rd_data;
    note_rec_t         ram_rec;
    note_rec_t         rec_cur;
    note_rec_t         rec_next;
    logic              wr_en;
    logic [NUM_KEYS-1:0] written_reg;
    logic              fwd_valid_reg;
    logic [KEY_W-1:0]  fwd_addr_reg;
    note_rec_t         fwd_rec_reg;

    note_t             scan_state;
    hist_t             scan_hist;
    logic [GAIN_W-1:0] scan_gain;
    logic              scan_restart;

    logic                     voice_live;
    logic                     voice_scale;
    logic signed [GAIN_W:0]   gain_dec;
    logic [GAIN_W-1:0]        gain_next;
    logic signed [PROD_W-1:0] product;

    // stage c: truncation of the scaled sample
    logic                       c_valid_reg;
    logic                       c_kind_reg;
    logic                       c_last_reg;
    logic                       c_active_reg;
    logic                       c_restart_reg;
    logic                       c_sum_en_reg;
    logic                       c_scale_reg;
    logic signed [PROD_W-1:0]   c_prod_reg;
    logic signed [SAMPLE_W-1:0] c_sample_reg;
    logic signed [PROD_W-1:0]   c_biased;
    logic signed [SCALED_W-1:0] c_scaled;

    // stage d: frame accumulation
    logic                       d_valid_reg;
    logic                       d_kind_reg;
    logic                       d_last_reg;
    logic                       d_active_reg;
    logic                       d_restart_reg;
    logic                       d_sum_en_reg;
    logic signed [SCALED_W-1:0] d_scaled_reg;
    logic signed [SUM_W-1:0]    frame_sum_reg;
    logic [TALLY_W-1:0]         tally_reg;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_next;
    logic [TALLY_W-1:0]         tally_next;

    // stage e: output formatting
    logic                    e_valid_reg;
    logic                    e_kind_reg;
    logic                    e_active_reg;
    logic                    e_restart_reg;
    logic signed [SUM_W-1:0] e_sum_reg;
    logic [TALLY_W-1:0]      e_count_reg;
    logic signed [SUM_W:0]   half_wide;
    logic signed [SUM_W-1:0] halved;
    logic signed [SUM_W-1:0] clamped;

    // issue only when the result queue has room for everything in flight
    assign occupancy = OCC_W'(out_count) + OCC_W'(b_valid_reg) + OCC_W'(c_valid_reg)
                     + OCC_W'(d_valid_reg) + OCC_W'(e_valid_reg);
    assign issue = !q_empty && (occupancy < OCC_W'(OUT_DEPTH));
    assign q_pop = issue;

    assign rd_addr = q_item.key[KEY_W-1:0];
    assign b_addr  = b_item_reg.key[KEY_W-1:0];
    assign wr_en   = b_valid_reg && b_item_reg.key_ok;

    pksm_ram #(
        .WIDTH ($bits(note_rec_t)),
        .DEPTH (NUM_KEYS)
    ) u_note_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (b_addr),
        .wr_data (rec_next),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ram_rec = note_rec_t'(ram_rd_data);

    // latest record: bypass the write of the previous cycle, unwritten keys read as reset
    always_comb
    begin
        if (!b_item_reg.key_ok)
        begin
            rec_cur = REC_RESET;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == b_addr))
        begin
            rec_cur = fwd_rec_reg;
        end
        else if (written_reg[b_addr])
        begin
            rec_cur = ram_rec;
        end
        else
        begin
            rec_cur = REC_RESET;
        end
    end

    // key scan update
    always_comb
    begin
        scan_state   = rec_cur.state;
        scan_hist    = rec_cur.hist;
        scan_gain    = rec_cur.gain;
        scan_restart = 1'b0;
        if (b_item_reg.key_down)
        begin
            scan_state = NOTE_HELD;
            if (rec_cur.hist == HIST_ARMED)
            begin
                scan_restart = 1'b1;
            end
            else
            begin
                scan_hist = HIST_PRESSED;
            end
        end
        else if (rec_cur.hist != HIST_NONE)
        begin
            scan_state = NOTE_SUSTAIN;
        end
        else
        begin
            scan_state = NOTE_IDLE;
            scan_hist  = HIST_NONE;
        end

        if (scan_state == NOTE_SUSTAIN && scan_hist == HIST_PRESSED)
        begin
            scan_hist = HIST_ARMED;
            scan_gain = GAIN_ONE;
        end
        else if (scan_hist == HIST_ARMED && scan_state == NOTE_HELD)
        begin
            scan_hist = HIST_PRESSED;
            scan_gain = '0;
        end
        else if (scan_hist == HIST_ARMED && rec_cur.gain <= gain_floor)
        begin
            scan_gain    = '0;
            scan_state   = NOTE_IDLE;
            scan_hist    = HIST_NONE;
            scan_restart = 1'b1;
        end
    end

    // voice sample: gain decay with floor
    assign voice_live  = b_item_reg.key_ok && (rec_cur.state != NOTE_IDLE);
    assign voice_scale = voice_live && (rec_cur.gain != '0);
    assign gain_dec    = $signed({1'b0, rec_cur.gain}) - $signed({6'b0, decay_step});
    assign gain_next   = (gain_dec <= $signed({1'b0, gain_floor})) ? gain_floor
                                                                     : gain_dec[GAIN_W-1:0];
    assign product     = b_item_reg.sample * $signed({1'b0, rec_cur.gain});

    always_comb
    begin
        rec_next = rec_cur;
        if (b_item_reg.kind == REQ_SCAN)
        begin
            rec_next.state = scan_state;
            rec_next.hist  = scan_hist;
            rec_next.gain  = scan_gain;
        end
        else if (voice_scale)
        begin
            rec_next.gain = gain_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            written_reg   <= '0;
            frame_sum_reg <= '0;
            tally_reg     <= '0;
        end
        else
        begin
            b_valid_reg   <= issue;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg && (d_kind_reg == REQ_SCAN || d_last_reg);
            fwd_valid_reg <= wr_en;
            if (wr_en)
            begin
                written_reg[b_addr] <= 1'b1;
            end
            if (d_valid_reg && d_kind_reg == REQ_VOICE)
            begin
                if (d_last_reg)
                begin
                    frame_sum_reg <= '0;
                    tally_reg     <= '0;
                end
                else
                begin
                    frame_sum_reg <= sum_next;
                    tally_reg     <= tally_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_item_reg    <= q_item;
        fwd_addr_reg  <= b_addr;
        fwd_rec_reg   <= rec_next;

        c_kind_reg    <= b_item_reg.kind;
        c_last_reg    <= b_item_reg.last;
        c_active_reg  <= b_item_reg.key_ok && (scan_state != NOTE_IDLE);
        c_restart_reg <= b_item_reg.key_ok && scan_restart;
        c_sum_en_reg  <= voice_live;
        c_scale_reg   <= voice_scale;
        c_prod_reg    <= product;
        c_sample_reg  <= b_item_reg.sample;

        d_kind_reg    <= c_kind_reg;
        d_last_reg    <= c_last_reg;
        d_active_reg  <= c_active_reg;
        d_restart_reg <= c_restart_reg;
        d_sum_en_reg  <= c_sum_en_reg;
        d_scaled_reg  <= c_scaled;

        e_kind_reg    <= d_kind_reg;
        e_active_reg  <= d_active_reg;
        e_restart_reg <= d_restart_reg;
        e_sum_reg     <= sum_next;
        e_count_reg   <= tally_next;
    end

    // divide by 2^20 truncating toward zero; with scaling off the sample passes unscaled
    assign c_biased = c_prod_reg + (c_prod_reg[PROD_W-1] ? ROUND_BIAS : '0);
    assign c_scaled = c_scale_reg ? c_biased[PROD_W-1:SCALE_SHIFT]
                                  : SCALED_W'(c_sample_reg);

    // saturating accumulate
    assign sum_wide = (SUM_W+1)'(frame_sum_reg) + (SUM_W+1)'(d_scaled_reg);

    always_comb
    begin
        sum_next   = frame_sum_reg;
        tally_next = tally_reg;
        if (d_sum_en_reg)
        begin
            if (sum_wide > SUM_MAX)
            begin
                sum_next = SUM_MAX[SUM_W-1:0];
            end
            else if (sum_wide < SUM_MIN)
            begin
                sum_next = SUM_MIN[SUM_W-1:0];
            end
            else
            begin
                sum_next = sum_wide[SUM_W-1:0];
            end
            if (tally_reg != TALLY_MAX)
            begin
                tally_next = tally_reg + 1'b1;
            end
        end
    end

    // halve toward zero and clamp
    assign half_wide = (SUM_W+1)'(e_sum_reg) + (SUM_W+1)'({1'b0, e_sum_reg[SUM_W-1]});
    assign halved    = half_wide[SUM_W:1];
    assign clamped   = (halved > OUT_HIGH) ? OUT_HIGH
                     : (halved < OUT_LOW)  ? OUT_LOW
                     : halved;

    always_comb
    begin
        res_data.kind    = e_kind_reg;
        res_data.active  = 1'b0;
        res_data.restart = 1'b0;
        res_data.mixed   = '0;
        res_data.count   = '0;
        if (e_kind_reg == RES_STATUS)
        begin
            res_data.active  = e_active_reg;
            res_data.restart = e_restart_reg;
        end
        else
        begin
            res_data.mixed = clamped[SAMPLE_W-1:0];
            res_data.count = e_count_reg;
        end
    end

    assign res_push = e_valid_reg;

endmodule

>>> design/polyphonic_key_sustain_mixer_unit.sv
// Polyphonic key sustain mixer.
// Input queue: push an item while full is low; req_type selects a key scan
// (key_index, key_down) or a voice sample (key_index, voice_sample,
// last_voice). Every key scan yields one status result; a voice sample
// yields a mixed frame result only when last_voice is set.
// Result queue: while empty is low the oldest result sits on the result
// ports; pop takes it.
// Configuration: cfg_index 0 writes decay_step, 1 writes gain_floor. The channel is
// always ready. The user writes it only while the block is idle; nothing enforces it.
// Throughput: one item per clock, sustained when the consumer pops every
// cycle. Path: after transfer an item passes the input queue, the per-key
// record read with multiply, truncate, accumulate, format and the result
// queue before it shows on the outputs. Issue from the input queue is held
// while the result queue cannot take every item in flight, so a stalled
// consumer backs the input queue up and full rises; no result is dropped.
// Reset: all keys idle with zero gain, frame sum and voice count cleared,
// both queues empty, registers at their defaults. No clearing pass: per-key
// valid bits make unwritten keys read as idle.
module polyphonic_key_sustain_mixer_unit
    import pksm_pkg::*;
#(
    parameter int NUM_KEYS    = 88,
    parameter int QUEUE_DEPTH = 4,
    parameter int OUT_DEPTH   = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        req_type,
    input  logic [KEY_IDX_W-1:0]        key_index,
    input  logic                        key_down,
    input  logic signed [SAMPLE_W-1:0]  voice_sample,
    input  logic                        last_voice,
    output logic                        empty,
    input  logic                        pop,
    output logic                        result_kind,
    output logic                        key_active,
    output logic                        restart_voice,
    output logic signed [SAMPLE_W-1:0]  mixed_sample,
    output logic [TALLY_W-1:0]          voice_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [GAIN_W-1:0]           cfg_data
);

    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    logic [DECAY_W-1:0]   decay_step_reg;
    logic [GAIN_W-1:0]    gain_floor_reg;
    logic                 q_empty;
    logic                 q_pop;
    item_t                q_item;
    logic                 res_push;
    res_t                 res_data;
    res_t                 out_data;
    logic                 out_full;
    logic [OUT_CNT_W-1:0] out_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_step_reg <= DECAY_STEP_RESET;
            gain_floor_reg <= GAIN_FLOOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DECAY_STEP: decay_step_reg <= cfg_data[DECAY_W-1:0];
                REG_GAIN_FLOOR: gain_floor_reg <= cfg_data;
                default:        gain_floor_reg <= gain_floor_reg;
            endcase
        end
    end

    pksm_front #(
        .NUM_KEYS    (NUM_KEYS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .key_index    (key_index),
        .key_down     (key_down),
        .voice_sample (voice_sample),
        .last_voice   (last_voice),
        .q_pop        (q_pop),
        .q_empty      (q_empty),
        .q_item       (q_item)
    );

    pksm_back #(
        .NUM_KEYS  (NUM_KEYS),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .decay_step (decay_step_reg),
        .gain_floor (gain_floor_reg),
        .q_empty    (q_empty),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_count  (out_count),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    // result queue; the back end only issues when there is room, so full never drops
    pksm_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push && !out_full),
        .wr_data (res_data),
        .pop     (pop),
        .rd_data (out_data),
        .full    (out_full),
        .empty   (empty),
        .count   (out_count)
    );

    assign result_kind   = out_data.kind;
    assign key_active    = out_data.active;
    assign restart_voice = out_data.restart;
    assign mixed_sample  = out_data.mixed;
    assign voice_count   = out_data.count;

endmodule
